// ===== hw/rtl/psc_pkg.sv =====
package psc_pkg;

    localparam int NORM_W  = 18;
    localparam int COORD_W = 24;
    localparam int OFFS_W  = 44;
    localparam int PROD_W  = NORM_W + COORD_W;
    localparam int SUM_W   = 45;
    localparam int DIST_W  = 48;
    localparam int CFG_W   = OFFS_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_OFFSET = 2'd3;

    typedef enum logic [1:0] {
        SIDE_NONE = 2'd0,
        SIDE_POS  = 2'd1,
        SIDE_NEG  = 2'd2,
        SIDE_BOTH = 2'd3
    } side_t;

    typedef logic signed [NORM_W-1:0] norm_t;
    typedef logic signed [OFFS_W-1:0] offs_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic signed [DIST_W-1:0] dist_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic is_box;
        logic box_null;
        logic box_infinite;
    } ctrl_t;

    typedef struct packed {
        prod_t x_lo;
        prod_t x_hi;
        prod_t y_lo;
        prod_t y_hi;
        prod_t z_lo;
        prod_t z_hi;
    } prods_t;

endpackage

// ===== hw/rtl/psc_mul_stage.sv =====
module psc_mul_stage (
    input  logic            clk,
    input  logic            en,
    input  psc_pkg::ctrl_t  ctrl,
    input  psc_pkg::vec_t   lo,
    input  psc_pkg::vec_t   hi,
    input  psc_pkg::norm_t  nx,
    input  psc_pkg::norm_t  ny,
    input  psc_pkg::norm_t  nz,
    output psc_pkg::ctrl_t  ctrl_out,
    output psc_pkg::prods_t prods
);
    import psc_pkg::*;

    prods_t prods_reg;
    prods_t prods_next;
    ctrl_t  ctrl_reg;

    always_comb
    begin
        prods_next.x_lo = nx * lo.x;
        prods_next.x_hi = nx * hi.x;
        prods_next.y_lo = ny * lo.y;
        prods_next.y_hi = ny * hi.y;
        prods_next.z_lo = nz * lo.z;
        prods_next.z_hi = nz * hi.z;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prods_reg <= prods_next;
            ctrl_reg  <= ctrl;
        end
    end

    assign prods    = prods_reg;
    assign ctrl_out = ctrl_reg;

endmodule

// ===== hw/rtl/psc_sum_stage.sv =====
module psc_sum_stage (
    input  logic            clk,
    input  logic            en,
    input  psc_pkg::ctrl_t  ctrl,
    input  psc_pkg::prods_t prods,
    input  psc_pkg::offs_t  offset,
    output psc_pkg::ctrl_t  ctrl_out,
    output psc_pkg::sum_t   xy [4],
    output psc_pkg::sum_t   zo [2]
);
    import psc_pkg::*;

    sum_t  xy_reg [4];
    sum_t  xy_next [4];
    sum_t  zo_reg [2];
    sum_t  zo_next [2];
    ctrl_t ctrl_reg;

    // xy index: bit 0 picks x max, bit 1 picks y max
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            xy_next[i] = SUM_W'(i[0] ? prods.x_hi : prods.x_lo)
                       + SUM_W'(i[1] ? prods.y_hi : prods.y_lo);
        end
        zo_next[0] = SUM_W'(prods.z_lo) + SUM_W'(offset);
        zo_next[1] = SUM_W'(prods.z_hi) + SUM_W'(offset);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xy_reg   <= xy_next;
            zo_reg   <= zo_next;
            ctrl_reg <= ctrl;
        end
    end

    assign xy       = xy_reg;
    assign zo       = zo_reg;
    assign ctrl_out = ctrl_reg;

endmodule

// ===== hw/rtl/psc_classify.sv =====
module psc_classify (
    input  psc_pkg::ctrl_t ctrl,
    input  psc_pkg::sum_t  xy [4],
    input  psc_pkg::sum_t  zo [2],
    output psc_pkg::side_t side,
    output psc_pkg::dist_t distance
);
    import psc_pkg::*;

    sum_t  corner [8];
    side_t csd [8];
    logic  mismatch;

    function automatic side_t side_of(input sum_t d);
        side_t s;
        if (d[SUM_W-1])
            s = SIDE_NEG;
        else if (d != '0)
            s = SIDE_POS;
        else
            s = SIDE_NONE;
        return s;
    endfunction

    always_comb
    begin
        mismatch = 1'b0;
        for (int c = 0; c < 8; c++)
        begin
            corner[c] = xy[c[1:0]] + zo[c[2]];
            csd[c]    = side_of(corner[c]);
        end
        for (int c = 1; c < 8; c++)
        begin
            if (csd[c] != csd[0])
                mismatch = 1'b1;
        end

        if (!ctrl.is_box)
        begin
            side     = csd[0];
            distance = DIST_W'(corner[0]);
        end
        else
        begin
            distance = '0;
            if (ctrl.box_null)
                side = SIDE_NONE;
            else if (ctrl.box_infinite || mismatch)
                side = SIDE_BOTH;
            else
                side = csd[0];
        end
    end

endmodule

// ===== hw/rtl/plane_side_classifier.sv =====
// Plane side classifier: a four-stage pipeline that takes one point or box item per cycle
// when the output is not stalled and returns one result per item. Stages are the input
// register, six parallel 18x24 normal-by-coordinate multipliers, the partial corner sums
// with the plane offset, and the final corner sums with the side decision. A stall on
// the output fills the empty stages first and only then raises in_stall. Plane registers
// are written through cfg_we/cfg_index/cfg_data.
module plane_side_classifier (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psc_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic signed [psc_pkg::COORD_W-1:0]  min_x,
    input  logic signed [psc_pkg::COORD_W-1:0]  min_y,
    input  logic signed [psc_pkg::COORD_W-1:0]  min_z,
    input  logic signed [psc_pkg::COORD_W-1:0]  max_x,
    input  logic signed [psc_pkg::COORD_W-1:0]  max_y,
    input  logic signed [psc_pkg::COORD_W-1:0]  max_z,
    input  logic                                box_null,
    input  logic                                box_infinite,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          side,
    output logic signed [psc_pkg::DIST_W-1:0]   distance
);
    import psc_pkg::*;

    norm_t  nx_reg;
    norm_t  ny_reg;
    norm_t  nz_reg;
    offs_t  offset_reg;

    logic   v1_reg;
    logic   v2_reg;
    logic   v3_reg;
    logic   v4_reg;
    logic   rdy1;
    logic   rdy2;
    logic   rdy3;
    logic   rdy4;

    ctrl_t  ctrl1_reg;
    vec_t   lo_reg;
    vec_t   hi_reg;

    ctrl_t  ctrl2;
    prods_t prods;
    ctrl_t  ctrl3;
    sum_t   xy [4];
    sum_t   zo [2];

    side_t  side_next;
    dist_t  dist_next;
    side_t  side_reg;
    dist_t  dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg     <= '0;
            ny_reg     <= '0;
            nz_reg     <= '0;
            offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NORMAL_X:     nx_reg     <= cfg_data[NORM_W-1:0];
                CFG_NORMAL_Y:     ny_reg     <= cfg_data[NORM_W-1:0];
                CFG_NORMAL_Z:     nz_reg     <= cfg_data[NORM_W-1:0];
                CFG_PLANE_OFFSET: offset_reg <= cfg_data[OFFS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign rdy4     = !v4_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            ctrl1_reg.is_box       <= cmd;
            ctrl1_reg.box_null     <= box_null;
            ctrl1_reg.box_infinite <= box_infinite;
            lo_reg.x <= min_x;
            lo_reg.y <= min_y;
            lo_reg.z <= min_z;
            hi_reg.x <= max_x;
            hi_reg.y <= max_y;
            hi_reg.z <= max_z;
        end
    end

    psc_mul_stage u_mul (
        .clk      (clk),
        .en       (rdy2),
        .ctrl     (ctrl1_reg),
        .lo       (lo_reg),
        .hi       (hi_reg),
        .nx       (nx_reg),
        .ny       (ny_reg),
        .nz       (nz_reg),
        .ctrl_out (ctrl2),
        .prods    (prods)
    );

    psc_sum_stage u_sum (
        .clk      (clk),
        .en       (rdy3),
        .ctrl     (ctrl2),
        .prods    (prods),
        .offset   (offset_reg),
        .ctrl_out (ctrl3),
        .xy       (xy),
        .zo       (zo)
    );

    psc_classify u_cls (
        .ctrl     (ctrl3),
        .xy       (xy),
        .zo       (zo),
        .side     (side_next),
        .distance (dist_next)
    );

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            side_reg <= side_next;
            dist_reg <= dist_next;
        end
    end

    assign out_valid = v4_reg;
    assign side      = side_reg;
    assign distance  = dist_reg;

`ifndef NO_ASSERTIONS
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && v4_reg)
        else $error("input stalled with an empty stage");

    a_dist_side: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && distance != '0 |-> side_reg == SIDE_POS || side_reg == SIDE_NEG)
        else $error("nonzero distance with box or none side");

    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && distance != '0 && side_reg == SIDE_POS |-> !distance[DIST_W-1])
        else $error("positive side with negative distance");
`endif

endmodule
